/* hdl/bafq_pkg.sv */
// package for the bump allocator with free queue
// request and status codes, stream field widths; no dependencies
package bafq_pkg;

  localparam int unsigned SizeW   = 31;
  localparam int unsigned AlignW  = 5;
  localparam int unsigned OutAddrW = 48;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned OffW    = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned UserW    = 3;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_ALIGNED = 2'd1,
    REQ_FREE    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_PAST_LIMIT = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  localparam logic [CfgIdxW-1:0] CFG_POOL0_BASE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POOL1_BASE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_POOL0_LIMIT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_POOL1_LIMIT = 2'd3;

  localparam logic [LimitW-1:0] POOL0_LIMIT_RST = 31'd65536;
  localparam logic [LimitW-1:0] POOL1_LIMIT_RST = 31'd1073741824;

  localparam int unsigned ReuseMin = 2;

endpackage

/* hdl/bump_allocator_with_free_queue.sv */
// top level of the bump allocator with free queue
// per-pool bump offsets in registers, freed addresses in one ring memory; uses bafq_pkg
//
// a request is captured on acceptance along with a registered read of the queue memory;
// its result is registered in the execute state once the output register is free, and a
// held result keeps the next request waiting; no request is taken while in execute
// reset: offsets, queue tails and counts cleared, limits to their defaults, no clearing pass
module bump_allocator_with_free_queue
  import bafq_pkg::*;
#(
  parameter int unsigned NUM_POOLS  = 2,
  parameter int unsigned FREE_DEPTH = 1024,
  parameter int unsigned ADDR_BITS  = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [OutAddrW-1:0] cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // req_size, align_log2, free_addr, zero pad
  input  logic [UserW-1:0]    s_axis_tuser,  // req_type, pool
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // result_addr
  output logic [UserW-1:0]    m_axis_tuser   // status, reused
);

  localparam int unsigned PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int unsigned TW = $clog2(FREE_DEPTH);
  localparam int unsigned CW = $clog2(FREE_DEPTH + 1);
  localparam int unsigned MD = NUM_POOLS * FREE_DEPTH;
  localparam int unsigned MW = $clog2(MD);
  localparam int unsigned SW = ((ADDR_BITS > OutAddrW) ? ADDR_BITS : OutAddrW) + 1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // configuration registers
  logic [OutAddrW-1:0] base0_q, base1_q;
  logic [LimitW-1:0]   limit0_q, limit1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base0_q  <= '0;
      base1_q  <= '0;
      limit0_q <= POOL0_LIMIT_RST;
      limit1_q <= POOL1_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_POOL0_BASE:  base0_q  <= cfg_data_i;
        CFG_POOL1_BASE:  base1_q  <= cfg_data_i;
        CFG_POOL0_LIMIT: limit0_q <= cfg_data_i[LimitW-1:0];
        CFG_POOL1_LIMIT: limit1_q <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [1:0]          in_type;
  logic                in_pool;
  logic [SizeW-1:0]    in_size;
  logic [AlignW-1:0]   in_lg;
  logic [OutAddrW-1:0] in_faddr;

  assign in_type  = s_axis_tuser[1:0];
  assign in_pool  = s_axis_tuser[2];
  assign in_size  = s_axis_tdata[SizeW-1:0];
  assign in_lg    = s_axis_tdata[SizeW+AlignW-1:SizeW];
  assign in_faddr = s_axis_tdata[SizeW+AlignW+OutAddrW-1:SizeW+AlignW];

  // per-pool state
  logic [OffW-1:0] off_q  [NUM_POOLS];
  logic [TW-1:0]   tail_q [NUM_POOLS];
  logic [CW-1:0]   cnt_q  [NUM_POOLS];

  state_e state_q;

  // captured request and values precomputed in the accept cycle
  req_e                 type_q;
  logic                 pool_ok_q;
  logic [PW-1:0]        pidx_q;
  logic [AlignW-1:0]    lg_q;
  logic [OutAddrW-1:0]  faddr_q;
  logic [LimitW-1:0]    limit_q;
  logic [ADDR_BITS-1:0] cur_q;     // base plus offset, wrapped
  logic [OffW:0]        offsz_q;   // offset plus size
  logic                 fit_q;

  // result register
  logic                 m_valid_q;
  logic [OutAddrW-1:0]  m_addr_q;
  status_e              m_status_q;
  logic                 m_reused_q;

  logic in_fire, out_free, exec_fire;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign exec_fire     = (state_q == S_EXEC) && out_free;

  // accept-cycle lookup
  logic                 a_pool_ok;
  logic [PW-1:0]        a_pidx;
  logic [OutAddrW-1:0]  a_base;
  logic [LimitW-1:0]    a_limit;
  logic [SW-1:0]        a_sum;
  logic [OffW:0]        a_offsz;
  logic [CW:0]          a_head_raw;
  logic [TW-1:0]        a_head;

  always_comb begin
    a_pool_ok = (32'(in_pool) < NUM_POOLS);
    a_pidx    = a_pool_ok ? PW'(in_pool) : '0;
    a_base    = in_pool ? base1_q : base0_q;
    a_limit   = in_pool ? limit1_q : limit0_q;
    a_sum     = SW'(a_base) + SW'(off_q[a_pidx]);
    a_offsz   = (OffW+1)'(off_q[a_pidx]) + (OffW+1)'(in_size);
    // oldest entry sits count slots behind the tail, modulo the ring depth
    a_head_raw = (CW+1)'(tail_q[a_pidx]) + (CW+1)'(FREE_DEPTH) - (CW+1)'(cnt_q[a_pidx]);
    if (a_head_raw >= (CW+1)'(FREE_DEPTH)) begin
      a_head_raw = a_head_raw - (CW+1)'(FREE_DEPTH);
    end
    a_head = a_head_raw[TW-1:0];
  end

  // free queue memory, all pools in one array
  logic [OutAddrW-1:0] mem [MD];
  logic [OutAddrW-1:0] mem_rdata_q;
  logic                mem_we;
  logic [MW-1:0]       mem_waddr, mem_raddr;

  assign mem_raddr = MW'(MW'(a_pidx) * MW'(FREE_DEPTH)) + MW'(a_head);
  assign mem_waddr = MW'(MW'(pidx_q) * MW'(FREE_DEPTH)) + MW'(tail_q[pidx_q]);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= faddr_q;
    end
    if (in_fire) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // execute cycle
  logic [LimitW-1:0]    x_amask;
  logic [ADDR_BITS-1:0] x_neg;
  logic [LimitW-1:0]    x_pad;
  logic [ADDR_BITS-1:0] x_al_addr;
  logic [OffW+1:0]      x_al_sum;
  logic [OffW-1:0]      x_al_off;
  logic [OffW-1:0]      x_bump_off;
  logic [CW-1:0]        x_cnt;
  logic [TW-1:0]        x_tail;
  logic [TW-1:0]        x_tail_next;
  logic                 x_reuse;
  logic                 x_full;
  logic [OutAddrW-1:0]  x_addr;
  status_e              x_status;
  logic                 x_reused;
  logic [OffW-1:0]      x_off_d;
  logic [CW-1:0]        x_cnt_d;
  logic [TW-1:0]        x_tail_d;

  always_comb begin
    x_amask    = LimitW'((OffW'(1) << lg_q) - OffW'(1));
    x_neg      = '0 - cur_q;
    x_pad      = x_neg[LimitW-1:0] & x_amask;
    x_al_addr  = cur_q + ADDR_BITS'(x_pad);
    x_al_sum   = (OffW+2)'(offsz_q) + (OffW+2)'(x_pad);
    // offsets saturate rather than wrap
    x_al_off   = (x_al_sum[OffW+1:OffW] != 2'b00) ? '1 : x_al_sum[OffW-1:0];
    x_bump_off = offsz_q[OffW] ? '1 : offsz_q[OffW-1:0];
    x_cnt      = cnt_q[pidx_q];
    x_tail     = tail_q[pidx_q];
    x_tail_next = (32'(x_tail) == FREE_DEPTH - 1) ? '0 : x_tail + TW'(1);
    x_reuse    = (32'(x_cnt) > ReuseMin);
    x_full     = (32'(x_cnt) >= FREE_DEPTH);

    x_addr   = '0;
    x_status = ST_OK;
    x_reused = 1'b0;
    x_off_d  = off_q[pidx_q];
    x_cnt_d  = x_cnt;
    x_tail_d = x_tail;
    mem_we   = 1'b0;

    if (pool_ok_q) begin
      unique case (type_q)
        REQ_ALLOC: begin
          priority if (x_reuse) begin
            x_addr   = mem_rdata_q;
            x_reused = 1'b1;
            x_cnt_d  = x_cnt - CW'(1);
          end else if (!fit_q) begin
            x_status = ST_NO_SPACE;
          end else begin
            x_addr  = OutAddrW'(cur_q);
            x_off_d = x_bump_off;
          end
        end
        REQ_ALIGNED: begin
          x_addr  = OutAddrW'(x_al_addr);
          x_off_d = x_al_off;
          if (x_al_off > OffW'(limit_q)) begin
            x_status = ST_PAST_LIMIT;
          end
        end
        REQ_FREE: begin
          if (x_full) begin
            x_status = ST_QUEUE_FULL;
          end else begin
            mem_we   = exec_fire;
            x_tail_d = x_tail_next;
            x_cnt_d  = x_cnt + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // control, per-pool state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_valid_q  <= 1'b0;
      m_addr_q   <= '0;
      m_status_q <= ST_OK;
      m_reused_q <= 1'b0;
      for (int i = 0; i < NUM_POOLS; i++) begin
        off_q[i]  <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      if (m_valid_q && m_axis_tready && !exec_fire) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_fire) begin
            state_q        <= S_IDLE;
            m_valid_q      <= 1'b1;
            m_addr_q       <= x_addr;
            m_status_q     <= x_status;
            m_reused_q     <= x_reused;
            off_q[pidx_q]  <= x_off_d;
            tail_q[pidx_q] <= x_tail_d;
            cnt_q[pidx_q]  <= x_cnt_d;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // request capture, payload only
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      type_q    <= req_e'(in_type);
      pool_ok_q <= a_pool_ok;
      pidx_q    <= a_pidx;
      lg_q      <= in_lg;
      faddr_q   <= in_faddr;
      limit_q   <= a_limit;
      cur_q     <= a_sum[ADDR_BITS-1:0];
      offsz_q   <= a_offsz;
      fit_q     <= (a_offsz <= (OffW+1)'(a_limit));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_addr_q;
  assign m_axis_tuser  = {m_reused_q, m_status_q};

  // checks
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_EXEC) && !s_axis_tready)
    else $error("accepted request did not enter execute");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_EXEC) && (type_q == REQ_FREE) && !x_full)
    else $error("queue write outside a stored free");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (32'(cnt_q[pidx_q]) <= FREE_DEPTH))
    else $error("queue count beyond ring depth");

  a_reused_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == ST_OK))
    else $error("reused address with failing status");

endmodule

/* tb/sv/bump_allocator_with_free_queue_tb.sv */
// testbench for the bump allocator with free queue: directed and random requests,
// checked against a behavioural model of both pools and their free rings
// depends on bafq_pkg and bump_allocator_with_free_queue only
module bump_allocator_with_free_queue_tb;
  import bafq_pkg::*;

  localparam int unsigned NumPools   = 2;
  localparam int unsigned RingDepth  = 1024;
  localparam int unsigned StallLimit = 4000;   // idle cycles before the run is abandoned
  localparam int unsigned HoldOff    = 400;    // long receiver stall for the pressure test
  localparam logic [63:0] AddrMask   = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] OffMax     = 64'h0000_0000_FFFF_FFFF;
  localparam logic [SizeW-1:0] SizeMax = 31'd1073741824;

  // one request as carried by the input stream
  typedef struct packed {
    req_e                 kind;
    logic                 pool;
    logic [SizeW-1:0]     size;
    logic [AlignW-1:0]    lg;
    logic [OutAddrW-1:0]  faddr;
  } alloc_req_t;

  // one result as carried by the output stream
  typedef struct packed {
    logic [OutAddrW-1:0]  addr;
    status_e              status;
    logic                 reused;
  } alloc_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [OutAddrW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // req_size, align_log2, free_addr, zero pad
  logic [UserW-1:0]     s_axis_tuser;   // req_type, pool
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;   // result_addr
  logic [UserW-1:0]     m_axis_tuser;   // status, reused

  bump_allocator_with_free_queue #(
    .NUM_POOLS  (NumPools),
    .FREE_DEPTH (RingDepth),
    .ADDR_BITS  (48)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // model state: configuration copy, bump offsets and the freed-address rings
  // ---------------------------------------------------------------------------
  logic [OutAddrW-1:0] cfg_base  [NumPools];
  logic [LimitW-1:0]   cfg_limit [NumPools];
  logic [63:0]         bump_off  [NumPools];   // wide so sums never wrap before clamping
  logic [OutAddrW-1:0] ring_mem  [NumPools][RingDepth];
  logic [9:0]          ring_tail [NumPools];
  logic [10:0]         ring_count[NumPools];

  alloc_rsp_t awaited_results[$];   // expected results, oldest first

  int unsigned mismatches;
  int unsigned requests_taken;
  int unsigned results_seen;
  int unsigned n_reused, n_no_space, n_past_limit, n_ring_full;
  int unsigned idle_cycles;

  // sender and receiver shaping, changed by the tests between phases
  bit          gaps_on;
  int unsigned burst_left;
  logic [15:0] stall_mask;
  int unsigned stall_ptr;
  int unsigned hold_request;
  int unsigned hold_left;

  // offsets stop at the top of the 32-bit range rather than wrapping
  function automatic logic [63:0] clamp_offset(logic [63:0] v);
    return (v > OffMax) ? OffMax : v;
  endfunction

  // advances the model by one request and returns the result it should give
  function automatic alloc_rsp_t predict_allocation(alloc_req_t rq);
    alloc_rsp_t  rsp;
    logic [63:0] cur;
    logic [63:0] pad;
    logic [63:0] sum;
    logic [9:0]  head;
    int unsigned p;
    rsp.addr   = '0;
    rsp.status = ST_OK;
    rsp.reused = 1'b0;
    p = 32'(rq.pool);
    case (rq.kind)
      REQ_ALLOC: begin
        if (ring_count[p] > ReuseMin) begin
          // oldest entry sits count slots behind the tail, modulo the ring
          head = ring_tail[p] - ring_count[p][9:0];
          rsp.addr = ring_mem[p][head];
          rsp.reused = 1'b1;
          ring_count[p] = ring_count[p] - 11'd1;
        end else if (bump_off[p] + rq.size > cfg_limit[p]) begin
          rsp.status = ST_NO_SPACE;
        end else begin
          sum = cfg_base[p] + bump_off[p];
          rsp.addr = sum[OutAddrW-1:0];
          bump_off[p] = clamp_offset(bump_off[p] + rq.size);
        end
      end
      REQ_ALIGNED: begin
        // round up to the alignment; warn only, the bump always happens
        cur = (cfg_base[p] + bump_off[p]) & AddrMask;
        pad = (64'd0 - cur) & ((64'd1 << rq.lg) - 64'd1);
        sum = (cur + pad) & AddrMask;
        rsp.addr = sum[OutAddrW-1:0];
        bump_off[p] = clamp_offset(bump_off[p] + pad + rq.size);
        if (bump_off[p] > cfg_limit[p]) rsp.status = ST_PAST_LIMIT;
      end
      REQ_FREE: begin
        if (ring_count[p] >= RingDepth) begin
          rsp.status = ST_QUEUE_FULL;
        end else begin
          ring_mem[p][ring_tail[p]] = rq.faddr;
          ring_tail[p] = ring_tail[p] + 10'd1;
          ring_count[p] = ring_count[p] + 11'd1;
        end
      end
      default: ;   // unused request code gives an all-zero result
    endcase
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts on every request transaction, checks every result
  // transaction, and runs the watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    alloc_req_t rq;
    alloc_rsp_t want;
    alloc_rsp_t got;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rq.kind  = req_e'(s_axis_tuser[1:0]);
        rq.pool  = s_axis_tuser[2];
        rq.size  = s_axis_tdata[SizeW-1:0];
        rq.lg    = s_axis_tdata[SizeW +: AlignW];
        rq.faddr = s_axis_tdata[SizeW+AlignW +: OutAddrW];
        want = predict_allocation(rq);
        awaited_results.push_back(want);
        requests_taken++;
        moved = 1'b1;
        if (want.reused) n_reused++;
        case (want.status)
          ST_NO_SPACE:   n_no_space++;
          ST_PAST_LIMIT: n_past_limit++;
          ST_QUEUE_FULL: n_ring_full++;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        results_seen++;
        got.addr   = m_axis_tdata[OutAddrW-1:0];
        got.status = status_e'(m_axis_tuser[1:0]);
        got.reused = m_axis_tuser[2];
        if (awaited_results.size() == 0) begin
          // a result nobody asked for
          if (mismatches < 10)
            $display("%0t: result with nothing awaited: addr %h status %0d reused %0b",
                     $time, got.addr, got.status, got.reused);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (got.addr !== want.addr || got.status !== want.status ||
              got.reused !== want.reused) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected addr %h status %0d reused %0b, got addr %h status %0d reused %0b",
                       $time, want.addr, want.status, want.reused,
                       got.addr, got.status, got.reused);
            mismatches++;
          end
        end
      end
    end
    // watchdog: too long without any transaction means the block has hung
    if (moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d results still awaited",
                 $time, idle_cycles, awaited_results.size());
        $display("bump_allocator_with_free_queue_tb: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stalls on a repeating mask, or holds off for a long stretch
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= stall_mask[stall_ptr % 16];
      stall_ptr++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic alloc_req_t make_request(req_e kind, logic pool, logic [SizeW-1:0] size,
                                              logic [AlignW-1:0] lg,
                                              logic [OutAddrW-1:0] faddr);
    alloc_req_t rq;
    rq.kind  = kind;
    rq.pool  = pool;
    rq.size  = size;
    rq.lg    = lg;
    rq.faddr = faddr;
    return rq;
  endfunction

  // mostly small sizes; huge sizes and alignments only on pool zero so that
  // pool one's offset grows only slowly over the run
  function automatic alloc_req_t random_request();
    alloc_req_t  rq;
    int unsigned pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    rq.kind = (pick < 35) ? REQ_ALLOC : (pick < 55) ? REQ_ALIGNED :
              (pick < 93) ? REQ_FREE : REQ_NONE;
    rq.pool = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 19);
    if (pick < 14)
      rq.size = SizeW'($urandom_range(0, 4095));
    else if (pick < 19)
      rq.size = SizeW'($urandom_range(0, 65535));
    else if (rq.pool == 1'b0)
      rq.size = SizeW'($urandom_range(0, SizeMax));
    else
      rq.size = SizeW'($urandom_range(0, 1 << 20));
    if (rq.kind == REQ_ALIGNED && rq.pool)
      rq.lg = AlignW'($urandom_range(0, 12));
    else
      rq.lg = AlignW'($urandom_range(0, 31));
    wide = {$urandom, $urandom};
    rq.faddr = wide[OutAddrW-1:0];
    return rq;
  endfunction

  // offers one request and returns once it has been taken
  task automatic send_request(alloc_req_t rq);
    @(negedge clk_i);
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-SizeW-AlignW-OutAddrW){1'b0}}, rq.faddr, rq.lg, rq.size};
    s_axis_tuser  <= {rq.pool, rq.kind};
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  // stops offering and waits until the block has nothing left in flight
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);   // margin after the last result
  endtask

  // register write, mirrored into the model; only called while idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [OutAddrW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_POOL0_BASE:  cfg_base[0]  = val;
      CFG_POOL1_BASE:  cfg_base[1]  = val;
      CFG_POOL0_LIMIT: cfg_limit[0] = val[LimitW-1:0];
      CFG_POOL1_LIMIT: cfg_limit[1] = val[LimitW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default limits: zero size, exact fit, out of space, unused code, aligned
  // rounding, reuse once the ring holds three entries, then back to bumping
  task automatic test_reset_defaults();
    gaps_on = 1'b0;
    stall_mask = 16'hFFFF;
    send_request(make_request(REQ_ALLOC,   1'b0, 31'd0,     5'd0,  48'd0));
    send_request(make_request(REQ_ALLOC,   1'b0, 31'd65536, 5'd0,  48'd0));
    send_request(make_request(REQ_ALLOC,   1'b0, 31'd1,     5'd0,  48'd0));
    send_request(make_request(REQ_NONE,    1'b1, '1,        '1,    '1));
    send_request(make_request(REQ_ALIGNED, 1'b1, 31'd3,     5'd16, 48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b1, 31'd0,     5'd4,  48'd0));
    send_request(make_request(REQ_FREE,    1'b1, 31'd0,     5'd0,  48'd0));
    send_request(make_request(REQ_FREE,    1'b1, 31'd0,     5'd0,  48'hFFFF_FFFF_FFFF));
    send_request(make_request(REQ_FREE,    1'b1, 31'd0,     5'd0,  48'hA5A5_5A5A_C3C3));
    send_request(make_request(REQ_ALLOC,   1'b1, 31'd5,     5'd0,  48'd0));
    send_request(make_request(REQ_ALLOC,   1'b1, 31'd5,     5'd0,  48'd0));
    settle_block();
  endtask

  // extreme settings: top-of-range base so addresses wrap, zero limit, the
  // largest size and alignment, and pool zero's offset driven into saturation
  task automatic test_config_extremes();
    write_reg(CFG_POOL0_BASE,  48'hFFFF_FFFF_FFF0);
    write_reg(CFG_POOL1_BASE,  48'h8000_0000_0001);
    write_reg(CFG_POOL0_LIMIT, 48'd0);
    write_reg(CFG_POOL1_LIMIT, {17'd0, SizeMax});
    send_request(make_request(REQ_ALLOC,   1'b0, 31'd0,   5'd0,  48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b0, SizeMax, 5'd31, 48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b0, SizeMax, 5'd0,  48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b0, SizeMax, 5'd0,  48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b0, SizeMax, 5'd20, 48'd0));
    send_request(make_request(REQ_ALLOC,   1'b0, 31'd0,   5'd0,  48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b1, 31'd0,   5'd0,  48'd0));
    send_request(make_request(REQ_ALIGNED, 1'b1, 31'd1,   5'd1,  48'd0));
    send_request(make_request(REQ_ALLOC,   1'b1, SizeMax, 5'd0,  48'd0));
    send_request(make_request(REQ_ALLOC,   1'b1, 31'd64,  5'd0,  48'd0));
    settle_block();
  endtask

  // random mixed traffic over four register settings
  task automatic test_random_mix();
    logic [63:0] lim;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // no idling at all on either side
          write_reg(CFG_POOL0_BASE,  OutAddrW'({$urandom, $urandom}));
          write_reg(CFG_POOL1_BASE,  OutAddrW'({$urandom, $urandom}));
          write_reg(CFG_POOL0_LIMIT, {17'd0, SizeMax});
          gaps_on = 1'b0;
          stall_mask = 16'hFFFF;
        end
        1: begin
          // pool one limit just above its offset so failures mix with successes
          lim = bump_off[1] + $urandom_range(0, 200000);
          if (lim > SizeMax) lim = SizeMax;
          write_reg(CFG_POOL1_BASE,  OutAddrW'({$urandom, $urandom}));
          write_reg(CFG_POOL1_LIMIT, lim[OutAddrW-1:0]);
          gaps_on = 1'b1;
          stall_mask = 16'($urandom) | 16'h0001;
        end
        2: begin
          write_reg(CFG_POOL0_BASE,  '1);
          write_reg(CFG_POOL1_BASE,  48'd0);
          write_reg(CFG_POOL1_LIMIT, 48'd0);
          gaps_on = 1'b1;
          stall_mask = 16'hAAAA;
        end
        default: begin
          // base near the top of the address space so pool one wraps
          write_reg(CFG_POOL1_BASE,  48'hFFFF_FFFF_FFFF - $urandom_range(0, 100000));
          write_reg(CFG_POOL1_LIMIT, {17'd0, SizeMax});
          gaps_on = 1'b1;
          stall_mask = 16'($urandom) | 16'h0100;
        end
      endcase
      repeat (60) send_request(random_request());
      settle_block();
    end
  endtask

  // fill pool zero's ring until frees are refused while the receiver holds
  // off, so the output backs up and the input stalls; then drain part of it
  task automatic test_ring_full_pressure();
    logic [63:0] wide;
    gaps_on = 1'b0;
    stall_mask = 16'hFFFF;
    hold_request = HoldOff;
    repeat (RingDepth + 6) begin
      wide = {$urandom, $urandom};
      send_request(make_request(REQ_FREE, 1'b0, SizeW'($urandom), AlignW'($urandom),
                                wide[OutAddrW-1:0]));
    end
    // pool one's ring is separate and must still take a free
    send_request(make_request(REQ_FREE, 1'b1, 31'd0, 5'd0, 48'h0123_4567_89AB));
    gaps_on = 1'b1;
    stall_mask = 16'($urandom) | 16'h0010;
    repeat (200)
      send_request(make_request(REQ_ALLOC, 1'b0, SizeW'($urandom_range(0, 4095)),
                                AlignW'($urandom), '0));
    settle_block();
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_POOL0_BASE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    gaps_on       = 1'b0;
    burst_left    = 0;
    stall_mask    = 16'hFFFF;
    stall_ptr     = 0;
    hold_request  = 0;
    hold_left     = 0;
    mismatches    = 0;
    requests_taken = 0;
    results_seen  = 0;
    idle_cycles   = 0;
    n_reused = 0; n_no_space = 0; n_past_limit = 0; n_ring_full = 0;
    // model state after reset
    cfg_base[0]  = '0;
    cfg_base[1]  = '0;
    cfg_limit[0] = POOL0_LIMIT_RST;
    cfg_limit[1] = POOL1_LIMIT_RST;
    for (int p = 0; p < NumPools; p++) begin
      bump_off[p]   = '0;
      ring_tail[p]  = '0;
      ring_count[p] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_config_extremes();
    test_random_mix();
    test_ring_full_pressure();

    // everything answered; wait on for stray results
    settle_block();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests and %0d results over several pool settings",
             requests_taken, results_seen);
    $display("reuses %0d, out of space %0d, past limit %0d, ring full %0d, mismatches %0d",
             n_reused, n_no_space, n_past_limit, n_ring_full, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("bump_allocator_with_free_queue_tb: done, clean");
    end else begin
      $display("bump_allocator_with_free_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bafq_pkg.sv
hdl/bump_allocator_with_free_queue.sv
tb/sv/bump_allocator_with_free_queue_tb.sv
